// File: src/e2r_pkg.sv
`default_nettype none
package e2r_pkg;
	localparam int AngW = 16;
	localparam int CordW = 34;
	localparam int TrigW = 18;
	localparam int ProdW = 36;
	localparam int TripW = 54;
	localparam int MaxIter = 24;
	localparam int OutW = 16;

	localparam logic signed [CordW-1:0] Q29Pi = 34'sd1686629713;
	localparam logic signed [CordW-1:0] Q29HalfPi = 34'sd843314857;
	localparam logic signed [CordW-1:0] Q29Gain = 34'sd326016437;

	typedef logic signed [AngW-1:0] angle_t;
	typedef logic signed [TrigW-1:0] trig_t;
	typedef logic signed [OutW-1:0] entry_t;

	typedef struct packed {
		angle_t angle_x;
		angle_t angle_y;
		angle_t angle_z;
	} angles_t;

	typedef struct packed {
		entry_t r00;
		entry_t r01;
		entry_t r02;
		entry_t r10;
		entry_t r11;
		entry_t r12;
		entry_t r20;
		entry_t r21;
		entry_t r22;
	} matrix_t;

	// sine and cosine of one angle
	typedef struct packed {
		trig_t s;
		trig_t c;
	} sincos_t;

	// arctangent table in Q29
	function automatic logic signed [CordW-1:0] atan_q29(input int i);
		logic signed [CordW-1:0] t;
		case (i)
			0: t = 34'sd421657428;
			1: t = 34'sd248918915;
			2: t = 34'sd131521918;
			3: t = 34'sd66762579;
			4: t = 34'sd33510843;
			5: t = 34'sd16771758;
			6: t = 34'sd8387925;
			7: t = 34'sd4194219;
			8: t = 34'sd2097141;
			9: t = 34'sd1048575;
			default: t = CordW'(34'sd524288 >>> (i - 10));
		endcase
		return t;
	endfunction
endpackage
`default_nettype wire

// File: src/e2r_if.sv
`default_nettype none
interface e2r_if #(
	parameter int W = 48
) (
	input wire logic clk
);
	logic valid;
	logic ready;
	logic [W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/e2r_cordic.sv
`default_nettype none
// Unrolled rotation-mode CORDIC, one register stage per iteration.
module e2r_cordic #(
	parameter int Iterations = 16
) (
	input wire logic clk,
	input wire logic en,
	input wire e2r_pkg::angle_t angle,
	output e2r_pkg::sincos_t sc
);
	localparam int N = (Iterations > e2r_pkg::MaxIter) ? e2r_pkg::MaxIter : Iterations;
	localparam int W = e2r_pkg::CordW;

	logic signed [W-1:0] x_s [N+1];
	logic signed [W-1:0] y_s [N+1];
	logic signed [W-1:0] z_s [N+1];
	logic flip_s [N+1];
	logic signed [W-1:0] z0;
	logic signed [W-1:0] xr;
	logic signed [W-1:0] yr;
	logic signed [W-1:0] xo;
	logic signed [W-1:0] yo;

	// fold the angle into [-pi/2, pi/2]
	assign z0 = W'(angle) <<< 16;
	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= e2r_pkg::Q29Gain;
			y_s[0] <= '0;
			if (z0 > e2r_pkg::Q29HalfPi) begin
				z_s[0] <= z0 - e2r_pkg::Q29Pi;
				flip_s[0] <= 1'b1;
			end else if (z0 < -e2r_pkg::Q29HalfPi) begin
				z_s[0] <= z0 + e2r_pkg::Q29Pi;
				flip_s[0] <= 1'b1;
			end else begin
				z_s[0] <= z0;
				flip_s[0] <= 1'b0;
			end
		end
	end

	// micro-rotations
	for (genvar i = 0; i < N; i++) begin : g_it
		always_ff @(posedge clk) begin
			if (en) begin
				flip_s[i+1] <= flip_s[i];
				if (!z_s[i][W-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - e2r_pkg::atan_q29(i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + e2r_pkg::atan_q29(i);
				end
			end
		end
	end

	// undo the fold, round to Q16
	assign xo = flip_s[N] ? -x_s[N] : x_s[N];
	assign yo = flip_s[N] ? -y_s[N] : y_s[N];
	assign xr = (xo + W'(4096)) >>> 13;
	assign yr = (yo + W'(4096)) >>> 13;
	always_ff @(posedge clk) begin
		if (en) begin
			sc.c <= xr[e2r_pkg::TrigW-1:0];
			sc.s <= yr[e2r_pkg::TrigW-1:0];
		end
	end
endmodule
`default_nettype wire

// File: src/e2r_matrix.sv
`default_nettype none
// Matrix products: pairwise stage, triple stage, sum and round stage.
module e2r_matrix (
	input wire logic clk,
	input wire logic en,
	input wire e2r_pkg::sincos_t scx,
	input wire e2r_pkg::sincos_t scy,
	input wire e2r_pkg::sincos_t scz,
	output e2r_pkg::matrix_t m
);
	localparam int PW = e2r_pkg::ProdW;
	localparam int TW = e2r_pkg::TripW;

	logic signed [PW-1:0] czcy_s1, czsy_s1, szsy_s1, szcy_s1, szcx_s1, szsx_s1;
	logic signed [PW-1:0] czcx_s1, czsx_s1, cysx_s1, cycx_s1;
	logic signed [e2r_pkg::TrigW-1:0] sx_s1, cx_s1, sy_s1;
	logic signed [TW-1:0] t00_s2, a01_s2, b01_s2, a02_s2, b02_s2, t10_s2;
	logic signed [TW-1:0] a11_s2, b11_s2, a12_s2, b12_s2, t20_s2, t21_s2, t22_s2;

	function automatic e2r_pkg::entry_t to_q14(input logic signed [TW-1:0] v);
		logic signed [TW-1:0] r;
		r = (v + (TW'(1) <<< 33)) >>> 34;
		if (r > TW'(16384)) r = TW'(16384);
		if (r < -TW'(16384)) r = -TW'(16384);
		return r[e2r_pkg::OutW-1:0];
	endfunction

	// pairwise products
	always_ff @(posedge clk) begin
		if (en) begin
			czcy_s1 <= scz.c * scy.c;
			czsy_s1 <= scz.c * scy.s;
			szsy_s1 <= scz.s * scy.s;
			szcy_s1 <= scz.s * scy.c;
			szcx_s1 <= scz.s * scx.c;
			szsx_s1 <= scz.s * scx.s;
			czcx_s1 <= scz.c * scx.c;
			czsx_s1 <= scz.c * scx.s;
			cysx_s1 <= scy.c * scx.s;
			cycx_s1 <= scy.c * scx.c;
			sx_s1 <= scx.s;
			cx_s1 <= scx.c;
			sy_s1 <= scy.s;
		end
	end

	// bring every term to Q48
	always_ff @(posedge clk) begin
		if (en) begin
			t00_s2 <= TW'(czcy_s1) <<< 16;
			a01_s2 <= czsy_s1 * sx_s1;
			b01_s2 <= TW'(szcx_s1) <<< 16;
			a02_s2 <= czsy_s1 * cx_s1;
			b02_s2 <= TW'(szsx_s1) <<< 16;
			t10_s2 <= TW'(szcy_s1) <<< 16;
			a11_s2 <= szsy_s1 * sx_s1;
			b11_s2 <= TW'(czcx_s1) <<< 16;
			a12_s2 <= szsy_s1 * cx_s1;
			b12_s2 <= TW'(czsx_s1) <<< 16;
			t20_s2 <= -(TW'(sy_s1) <<< 32);
			t21_s2 <= TW'(cysx_s1) <<< 16;
			t22_s2 <= TW'(cycx_s1) <<< 16;
		end
	end

	// combine, round and clamp
	always_ff @(posedge clk) begin
		if (en) begin
			m.r00 <= to_q14(t00_s2);
			m.r01 <= to_q14(a01_s2 - b01_s2);
			m.r02 <= to_q14(a02_s2 + b02_s2);
			m.r10 <= to_q14(t10_s2);
			m.r11 <= to_q14(a11_s2 + b11_s2);
			m.r12 <= to_q14(a12_s2 - b12_s2);
			m.r20 <= to_q14(t20_s2);
			m.r21 <= to_q14(t21_s2);
			m.r22 <= to_q14(t22_s2);
		end
	end
endmodule
`default_nettype wire

// File: src/euler_angles_to_rotation_matrix.sv
// Channel | Direction | Payload
// in_ch   | sink      | angle_x, angle_y, angle_z (Q3.13)
// out_ch  | source    | r00..r22 (Q2.14)
// One request per cycle sustained while out_ch.ready stays high; the pipeline
// is the unrolled CORDIC stages followed by three product stages.
// arst_n clears the valid bits only; data registers are not reset.
// A stall at the output freezes the whole pipeline, bubbles included;
// the input waits while the last stage holds a result that is not taken.
`default_nettype none
module euler_angles_to_rotation_matrix #(
	parameter int CORDIC_ITERATIONS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	e2r_if.sink in_ch,
	e2r_if.source out_ch
);
	localparam int N = (CORDIC_ITERATIONS > e2r_pkg::MaxIter) ?
		e2r_pkg::MaxIter : CORDIC_ITERATIONS;
	localparam int Depth = N + 5;

	logic [Depth-1:0] vld_q;
	logic en;
	e2r_pkg::angles_t ang;
	e2r_pkg::sincos_t scx, scy, scz;
	e2r_pkg::matrix_t mat;

	// advance when the last stage is empty or being taken
	assign en = !vld_q[Depth-1] || out_ch.ready;
	assign in_ch.ready = en;
	assign ang = in_ch.data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[Depth-2:0], in_ch.valid};
		end
	end

	e2r_cordic #(.Iterations(CORDIC_ITERATIONS)) u_cx (
		.clk(clk), .en(en), .angle(ang.angle_x), .sc(scx));
	e2r_cordic #(.Iterations(CORDIC_ITERATIONS)) u_cy (
		.clk(clk), .en(en), .angle(ang.angle_y), .sc(scy));
	e2r_cordic #(.Iterations(CORDIC_ITERATIONS)) u_cz (
		.clk(clk), .en(en), .angle(ang.angle_z), .sc(scz));

	e2r_matrix u_mat (
		.clk(clk), .en(en), .scx(scx), .scy(scy), .scz(scz), .m(mat));

	assign out_ch.valid = vld_q[Depth-1];
	assign out_ch.data = mat;

`ifndef SYNTHESIS
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
		else $error("result changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_ch.valid |-> in_ch.ready)
		else $error("input blocked with empty output");
	a_r20_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> ($signed(mat.r20) <= 16'sd16384 && $signed(mat.r20) >= -16'sd16384))
		else $error("entry out of range");
`endif
endmodule
`default_nettype wire

// File: dv/tb_euler_angles_to_rotation_matrix.sv
`default_nettype none
module tb_euler_angles_to_rotation_matrix;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int Iters = 16;
	localparam int Latency = Iters + 5;
	localparam int StallLimit = 5000;

	logic clk;
	logic arst_n;
	int errors = 0;
	int idle_cycles = 0;
	bit no_idle = 0;
	bit hold_out = 0;
	e2r_pkg::matrix_t matrix_q[$];

	e2r_if #(.W($bits(e2r_pkg::angles_t))) in_ch (.clk(clk));
	e2r_if #(.W($bits(e2r_pkg::matrix_t))) out_ch (.clk(clk));

	euler_angles_to_rotation_matrix #(.CORDIC_ITERATIONS(Iters)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// floor shift on a 64-bit signed value
	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	// sine and cosine in Q16 of a Q3.13 angle
	function automatic void sin_cos(input e2r_pkg::angle_t a, output longint s16,
		output longint c16);
		longint z, x, y, dx, dy, t;
		bit flip;
		z = longint'(a) * 65536;
		flip = 0;
		x = longint'(e2r_pkg::Q29Gain);
		y = 0;
		if (z > longint'(e2r_pkg::Q29HalfPi)) begin
			z -= longint'(e2r_pkg::Q29Pi);
			flip = 1;
		end else if (z < -longint'(e2r_pkg::Q29HalfPi)) begin
			z += longint'(e2r_pkg::Q29Pi);
			flip = 1;
		end
		for (int i = 0; i < Iters && i < e2r_pkg::MaxIter; i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (i < 10) begin
				case (i)
					0: t = 421657428; 1: t = 248918915; 2: t = 131521918;
					3: t = 66762579; 4: t = 33510843; 5: t = 16771758;
					6: t = 8387925; 7: t = 4194219; 8: t = 2097141;
					default: t = 1048575;
				endcase
			end else begin
				t = 64'sd524288 >>> (i - 10);
			end
			if (z >= 0) begin
				x -= dx; y += dy; z -= t;
			end else begin
				x += dx; y -= dy; z += t;
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c16 = floor_shift(x + 4096, 13);
		s16 = floor_shift(y + 4096, 13);
	endfunction

	// round Q48 to Q14 and clamp to plus or minus one
	function automatic e2r_pkg::entry_t round_q14(longint v48);
		longint r;
		r = floor_shift(v48 + (64'sd1 <<< 33), 34);
		if (r > 16384) r = 16384;
		if (r < -16384) r = -16384;
		return e2r_pkg::entry_t'(r);
	endfunction

	function automatic e2r_pkg::matrix_t rotation_of(e2r_pkg::angles_t a);
		longint sx, cx, sy, cy, sz, cz;
		longint u;
		e2r_pkg::matrix_t m;
		u = 65536;
		sin_cos(a.angle_x, sx, cx);
		sin_cos(a.angle_y, sy, cy);
		sin_cos(a.angle_z, sz, cz);
		m.r00 = round_q14(cz * cy * u);
		m.r01 = round_q14(cz * sy * sx - sz * cx * u);
		m.r02 = round_q14(cz * sy * cx + sz * sx * u);
		m.r10 = round_q14(sz * cy * u);
		m.r11 = round_q14(sz * sy * sx + cz * cx * u);
		m.r12 = round_q14(sz * sy * cx - cz * sx * u);
		m.r20 = round_q14(-sy * u * u);
		m.r21 = round_q14(cy * sx * u);
		m.r22 = round_q14(cy * cx * u);
		return m;
	endfunction

	// send one request, with random idle cycles before it; valid stays high
	// after acceptance so the next request can follow back to back
	task automatic send_angles(e2r_pkg::angle_t ax, e2r_pkg::angle_t ay,
		e2r_pkg::angle_t az);
		e2r_pkg::angles_t a;
		a.angle_x = ax;
		a.angle_y = ay;
		a.angle_z = az;
		while (!no_idle && $urandom_range(99) < 11) begin
			in_ch.valid <= 0;
			@(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.data <= a;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		matrix_q.push_back(rotation_of(a));
	endtask

	// drop valid and wait for every expected result
	task automatic wait_drain();
		in_ch.valid <= 0;
		while (matrix_q.size() != 0) @(posedge clk);
	endtask

	function automatic e2r_pkg::angle_t rand_angle();
		return e2r_pkg::angle_t'($urandom_range(65535));
	endfunction

	task automatic test_directed();
		e2r_pkg::angle_t corner[8];
		corner = '{16'sh0000, 16'sh7FFF, 16'sh8000, 16'sd12868, -16'sd12868,
			16'sd12869, -16'sd12869, 16'sd25736};
		for (int i = 0; i < 8; i++) send_angles(corner[i], corner[(i + 3) % 8],
			corner[(i + 5) % 8]);
		// each axis alone at an extreme, then mixed extremes and patterns on all axes
		send_angles(16'sh7FFF, 16'sd0, 16'sd0);
		send_angles(16'sd0, 16'sh7FFF, 16'sd0);
		send_angles(16'sd0, 16'sd0, 16'sh8000);
		send_angles(16'sh8000, 16'sh8000, 16'sh8000);
		send_angles(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		send_angles(-16'sd1, 16'sd1, -16'sd1);
		send_angles(16'sh5555, 16'shAAAA, 16'sh5555);
		send_angles(16'shAAAA, 16'sh5555, 16'shAAAA);
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++) send_angles(rand_angle(), rand_angle(), rand_angle());
	endtask

	// no idling on either side
	task automatic test_back_to_back(int n);
		no_idle = 1;
		test_random(n);
		no_idle = 0;
	endtask

	// hold the output so the pipeline fills and stalls its input
	task automatic test_backpressure();
		hold_out = 1;
		fork
			begin
				repeat (3 * Latency) @(posedge clk);
				hold_out = 0;
			end
			test_random(60);
		join
	endtask

	// accept results, with random stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 0;
		end else begin
			out_ch.ready <= !hold_out && (no_idle || $urandom_range(99) >= 11);
		end
	end

	// compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		e2r_pkg::matrix_t exp_m, got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			if (matrix_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
			end else begin
				exp_m = matrix_q.pop_front();
				for (int k = 0; k < 9; k++) begin
					if (exp_m[16 * k +: 16] !== got[16 * k +: 16]) begin
						$display("%0t: entry %0d expected %0d actual %0d", $time, 8 - k,
							$signed(exp_m[16 * k +: 16]), $signed(got[16 * k +: 16]));
						errors++;
					end
				end
			end
		end
	end

	// watchdog on cycles without any request moving
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles > StallLimit) begin
			$display("tb_euler_angles_to_rotation_matrix: done, errors");
			$finish;
		end
	end

	initial begin
		arst_n = 0;
		in_ch.valid = 0;
		in_ch.data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		wait_drain();
		test_random(300);
		test_backpressure();
		test_back_to_back(150);
		wait_drain();
		test_random(200);
		wait_drain();
		repeat (2 * Latency) @(posedge clk);
		if (errors == 0 && matrix_q.size() == 0) begin
			$display("tb_euler_angles_to_rotation_matrix: done, clean");
		end else begin
			$display("tb_euler_angles_to_rotation_matrix: done, errors");
		end
		$finish;
	end
endmodule
`default_nettype wire

// File: euler_angles_to_rotation_matrix.f
src/e2r_pkg.sv
src/e2r_if.sv
src/e2r_cordic.sv
src/e2r_matrix.sv
src/euler_angles_to_rotation_matrix.sv
dv/tb_euler_angles_to_rotation_matrix.sv
